/* rtl/core/rtwa_pkg.sv */
// Shared widths, action codes and the search word carried down the cell chain.
package rtwa_pkg;

  localparam int ENTRIES     = 64;
  localparam int TIME_BITS   = 32;
  localparam int MAC_W       = 48;
  localparam int HOP_W       = 8;
  localparam int LIMIT_W     = 16;
  localparam int ACT_W       = 2;
  localparam int LIMIT_RESET = 30;

  // age compare runs at the wider of the two operands
  localparam int CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

  localparam int IN_BITS  = 2 * MAC_W + HOP_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3 + MAC_W + HOP_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_FRESH  = 2'd2,
    ACT_TICK   = 2'd3
  } act_t;

  // word passed from cell to cell; done marks that a cell already handled it
  typedef struct packed {
    logic             vld;
    act_t             action;
    logic [MAC_W-1:0] dest;
    logic [MAC_W-1:0] nhop;
    logic [HOP_W-1:0] hops;
    logic             done;
    logic             found;
    logic             updated;
    logic [MAC_W-1:0] r_nhop;
    logic [HOP_W-1:0] r_hops;
  } tok_t;

endpackage

/* rtl/core/route_table_with_aging.sv */
// Route table top: cell chain search, seconds counter, stale limit and output stage.
// An accepted word is registered in the inject register, then in each cell in turn,
// then parks in the pending register until the output register frees up. One word at
// a time: the next word is taken once the previous one moves to the output register.
// Reset (rst_n low, synchronous): all entries invalid, seconds counter zero,
//   stale_limit back to 30, no word in flight, output empty.
module route_table_with_aging import rtwa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // config: stale_limit
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  // in_tuser: action[1:0]
  // in_tdata: dest_mac[47:0], gateway_mac[95:48], hop_count[103:96]
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ACT_W-1:0]   in_tuser,
  input  logic [IN_W-1:0]    in_tdata,
  // out_tdata: found[0], updated[1], table_full[2], route_gw[50:3],
  //            route_hops[58:51], zero pad[63:59]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  // stale limit register, to be written only while idle; the block does not enforce it
  logic [LIMIT_W-1:0]   stale_limit_r;
  // free running seconds, advanced by tick words
  logic [TIME_BITS-1:0] seconds_r;
  // one word in flight at a time
  logic                 busy_r;
  logic                 accept;

  // chain[0] is the injected word, chain[i+1] the output of cell i
  tok_t                 chain [0:ENTRIES];
  tok_t                 inj_r;

  // tail of the chain parks here until the output register frees up
  logic                 pend_v_r;
  tok_t                 pend_r;
  logic                 move;
  logic                 full;

  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_limit_r <= LIMIT_W'(LIMIT_RESET);
    end else if (cfg_wr_en) begin
      stale_limit_r <= cfg_wr_data;
    end
  end

  // tick takes effect at accept; the chain only carries its word to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r <= '0;
    end else if (accept && act_t'(in_tuser) == ACT_TICK) begin
      seconds_r <= seconds_r + 1'b1;
    end
  end

  // inject register: result fields start cleared, cells fill them in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r <= '0;
    end else begin
      inj_r.vld <= accept;
      if (accept) begin
        inj_r.action  <= act_t'(in_tuser);
        inj_r.dest    <= in_tdata[MAC_W-1:0];
        inj_r.nhop    <= in_tdata[2*MAC_W-1:MAC_W];
        inj_r.hops    <= in_tdata[2*MAC_W+HOP_W-1:2*MAC_W];
        inj_r.done    <= 1'b0;
        inj_r.found   <= 1'b0;
        inj_r.updated <= 1'b0;
        inj_r.r_nhop  <= '0;
        inj_r.r_hops  <= '0;
      end
    end
  end

  assign chain[0] = inj_r;

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    rtwa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .now_i   (seconds_r),
      .limit_i (stale_limit_r),
      .tok_i   (chain[gi]),
      .tok_o   (chain[gi+1])
    );
  end

  // an add that no cell took means no match and no vacant entry
  assign full = (pend_r.action == ACT_ADD) && !pend_r.done;
  assign move = pend_v_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (chain[ENTRIES].vld) begin
      pend_r <= chain[ENTRIES];
    end
    if (move) begin
      out_data_r <= OUT_W'({pend_r.r_hops, pend_r.r_nhop, full,
                            pend_r.updated, pend_r.found});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (move) begin
        busy_r <= 1'b0;
      end

      if (chain[ENTRIES].vld) begin
        pend_v_r <= 1'b1;
      end else if (move) begin
        pend_v_r <= 1'b0;
      end

      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/core/rtwa_cell.sv */
// One table entry plus one stage of the search word pipeline.
module rtwa_cell import rtwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [LIMIT_W-1:0]   limit_i,
  input  tok_t                 tok_i,
  output tok_t                 tok_o
);

  logic                 valid_r;
  logic [MAC_W-1:0]     dest_r;
  logic [MAC_W-1:0]     nhop_r;
  logic [HOP_W-1:0]     hops_r;
  logic [TIME_BITS-1:0] stamp_r;
  tok_t                 tok_r;
  tok_t                 tok_nxt;

  logic                 hit;
  logic                 vacant;
  logic [TIME_BITS-1:0] age;
  logic                 stale;
  logic                 wr_en;
  logic                 claim;

  always_comb begin
    tok_nxt = tok_i;
    hit     = tok_i.vld && !tok_i.done && valid_r && (dest_r == tok_i.dest);
    // valid entries form a prefix, so the first vacant cell ends an add's search
    vacant  = tok_i.vld && !tok_i.done && !valid_r;
    age     = now_i - stamp_r;
    stale   = CMP_W'(age) > CMP_W'(limit_i);
    wr_en   = 1'b0;
    claim   = 1'b0;
    unique case (tok_i.action)
      ACT_ADD: begin
        if (hit) begin
          tok_nxt.done = 1'b1;
          if (tok_i.hops < hops_r) begin
            wr_en           = 1'b1;
            tok_nxt.updated = 1'b1;
          end
        end else if (vacant) begin
          wr_en           = 1'b1;
          claim           = 1'b1;
          tok_nxt.done    = 1'b1;
          tok_nxt.updated = 1'b1;
        end
      end
      ACT_LOOKUP, ACT_FRESH: begin
        if (hit) begin
          tok_nxt.done = 1'b1;
          if (!(tok_i.action == ACT_FRESH && stale)) begin
            tok_nxt.found  = 1'b1;
            tok_nxt.r_nhop = nhop_r;
            tok_nxt.r_hops = hops_r;
          end
        end
      end
      ACT_TICK: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (claim) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      dest_r <= tok_i.dest;
    end
    if (wr_en) begin
      nhop_r  <= tok_i.nhop;
      hops_r  <= tok_i.hops;
      stamp_r <= now_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

/* rtl/core/rtwa_checker.sv */
// Port level checks for the route table, bound to the top level.
module rtwa_checker import rtwa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_W-1:0]   out_tdata
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while previous word still in flight");

  // found, updated and table_full exclude each other
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tdata[2:0]) <= 1)
    else $error("result flags not exclusive");

  // a miss carries no route
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OUT_W-1:3] == '0)
    else $error("route fields nonzero without a hit");

  // output empties on a reset edge
  a_no_early: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind route_table_with_aging rtwa_checker u_rtwa_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for the aging route table: bursty words in, stalling results out.
module tb_top;
  import rtwa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SZ   = 96;   // candidate destinations, more than the table holds
  localparam int PHASE_LEN = 80;   // random words per stale_limit setting
  localparam int N_PHASES  = 5;
  localparam int HOLD_LEN  = 600;  // long output hold-off, in cycles
  localparam int DRAIN_CYC = 70;   // a bit over the word latency through the cell chain

  // one word on the input channel
  typedef struct {
    act_t             action;
    logic [MAC_W-1:0] dest;
    logic [MAC_W-1:0] nhop;
    logic [HOP_W-1:0] hops;
  } route_word_t;

  // one result word, unpacked from out_tdata
  typedef struct packed {
    logic             found;
    logic             updated;
    logic             full;
    logic [MAC_W-1:0] route_gw;
    logic [HOP_W-1:0] hops;
  } route_result_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [ACT_W-1:0]   in_tuser    = '0;
  logic [IN_W-1:0]    in_tdata    = '0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [OUT_W-1:0]   out_tdata;

  route_table_with_aging DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),    // action[1:0]
    .in_tdata    (in_tdata),    // dest_mac[47:0], gateway_mac[95:48], hop_count[103:96]
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)    // found[0], updated[1], table_full[2], route_gw[50:3],
                                // hops[58:51], pad[63:59]
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shadow route table: our own copy of entries, seconds and stale limit.
  // ---------------------------------------------------------------------------
  logic                 tbl_valid [ENTRIES];
  logic [MAC_W-1:0]     tbl_dest  [ENTRIES];
  logic [MAC_W-1:0]     tbl_nhop  [ENTRIES];
  logic [HOP_W-1:0]     tbl_hops  [ENTRIES];
  logic [TIME_BITS-1:0] tbl_stamp [ENTRIES];
  logic [TIME_BITS-1:0] sec_now;
  logic [LIMIT_W-1:0]   stale_lim;

  route_word_t   pending_words[$];     // words waiting for the driver
  route_result_t expected_routes[$];   // predicted results, oldest first

  int  n_queued   = 0;
  int  n_accepted = 0;
  int  n_results  = 0;
  int  fail_cnt   = 0;
  bit  word_taken = 1'b0;              // set on the edge the current word is accepted

  // coverage-ish tallies for the summary
  int  n_adds = 0, n_lookups = 0, n_ticks = 0;
  int  n_updates = 0, n_drops = 0, n_hits = 0, n_stale = 0;

  // Apply one accepted word to the shadow table and return the result it should give.
  function automatic route_result_t apply_route_word(route_word_t w);
    route_result_t        r;
    int                   slot;
    int                   free_slot;
    logic [TIME_BITS-1:0] age;
    r = '0;
    slot = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && tbl_valid[i] && tbl_dest[i] == w.dest) slot = i;
      if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
    end
    case (w.action)
      ACT_ADD: begin
        n_adds++;
        if (slot < 0 && free_slot < 0) begin
          // new destination, no room: dropped
          r.full = 1'b1;
          n_drops++;
        end else if (slot < 0 || w.hops < tbl_hops[slot]) begin
          // new destination takes the lowest free entry; known one only on a shorter route
          if (slot < 0) slot = free_slot;
          tbl_valid[slot] = 1'b1;
          tbl_dest[slot]  = w.dest;
          tbl_nhop[slot]  = w.nhop;
          tbl_hops[slot]  = w.hops;
          tbl_stamp[slot] = sec_now;
          r.updated = 1'b1;
          n_updates++;
        end
      end
      ACT_LOOKUP, ACT_FRESH: begin
        n_lookups++;
        if (slot >= 0) begin
          age = sec_now - tbl_stamp[slot];   // wraps at TIME_BITS
          if (w.action == ACT_FRESH && age > stale_lim) begin
            n_stale++;
          end else begin
            r.found    = 1'b1;
            r.route_gw = tbl_nhop[slot];
            r.hops     = tbl_hops[slot];
            n_hits++;
          end
        end
      end
      default: begin
        // tick: payload fields are don't-care
        n_ticks++;
        sec_now = sec_now + 1'b1;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: config writes, input acceptance (predict) and result check.
  // Results are checked before the new word is predicted so a same-edge
  // accept can never satisfy its own expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    route_word_t   w;
    route_result_t got;
    route_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      sec_now   = '0;
      stale_lim = LIMIT_W'(LIMIT_RESET);
    end else begin
      if (cfg_wr_en) stale_lim = cfg_wr_data;

      if (out_tvalid && out_tready) begin
        got.found    = out_tdata[0];
        got.updated  = out_tdata[1];
        got.full     = out_tdata[2];
        got.route_gw = out_tdata[3 +: MAC_W];
        got.hops     = out_tdata[3 + MAC_W +: HOP_W];
        n_results++;
        if (expected_routes.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result word with nothing expected: %p", $realtime, got);
        end else begin
          want = expected_routes.pop_front();
          if (got.found !== want.found || got.updated !== want.updated ||
              got.full !== want.full || got.route_gw !== want.route_gw ||
              got.hops !== want.hops) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: result %0d exp f/u/full=%b%b%b %h/%0d got %b%b%b %h/%0d",
                       $realtime, n_results, want.found, want.updated, want.full,
                       want.route_gw, want.hops, got.found, got.updated, got.full,
                       got.route_gw, got.hops);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        w.action = act_t'(in_tuser);
        w.dest   = in_tdata[0 +: MAC_W];
        w.nhop   = in_tdata[MAC_W +: MAC_W];
        w.hops   = in_tdata[2*MAC_W +: HOP_W];
        expected_routes.push_back(apply_route_word(w));
        n_accepted++;
        word_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge, bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    route_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_tuser  <= w.action;
        in_tdata  <= IN_W'({w.hops, w.nhop, w.dest});
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          // end of burst: roughly a third of bursts run straight into the next one
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall rate re-rolled at random intervals (including no stalls),
  // plus one long hold-off once traffic is flowing so the input backs up.
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && n_results >= 150) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end else begin
        mode_left--;
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [MAC_W-1:0] dest_pool [POOL_SZ];
  logic [HOP_W-1:0] pool_hops [POOL_SZ];   // last hop count offered per pool entry
  int               pool_used = 0;

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  task automatic queue_word(act_t act, logic [MAC_W-1:0] dest, logic [MAC_W-1:0] nhop,
                            logic [HOP_W-1:0] hops);
    route_word_t w;
    w.action = act;
    w.dest   = dest;
    w.nhop   = nhop;
    w.hops   = hops;
    pending_words.push_back(w);
    n_queued++;
  endtask

  // Adds mostly draw from a pool of destinations: half of them a not-yet-used
  // one, so the table fills up partway through and later new ones get dropped.
  // Lookups mostly hit pool entries so hits, misses and stale rejections all show.
  task automatic queue_random_words(int n);
    int               sel;
    int               idx;
    logic [MAC_W-1:0] d;
    logic [HOP_W-1:0] h;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        if (pool_used == 0 || ($urandom_range(0, 1) == 0 && pool_used < POOL_SZ)) begin
          idx = pool_used;
          pool_used++;
          h = HOP_W'($urandom());
        end else if ($urandom_range(0, 9) == 0) begin
          idx = -1;
          h = HOP_W'($urandom());
        end else begin
          idx = $urandom_range(0, pool_used - 1);
          case ($urandom_range(0, 3))
            0:       h = pool_hops[idx];                                  // equal
            1:       h = (pool_hops[idx] == 0) ? '0 : pool_hops[idx] - 1; // shorter
            default: h = HOP_W'($urandom());
          endcase
        end
        if (idx >= 0) begin
          d = dest_pool[idx];
          pool_hops[idx] = h;
        end else begin
          d = rand_mac();
        end
        queue_word(ACT_ADD, d, rand_mac(), h);
      end else if (sel < 80) begin
        sel = $urandom_range(0, 99);
        if (sel < 70 && pool_used > 0) d = dest_pool[$urandom_range(0, pool_used - 1)];
        else if (sel < 85)             d = rand_mac();
        else                           d = ($urandom_range(0, 1) == 0) ? '0 : '1;
        queue_word(($urandom_range(0, 1) == 0) ? ACT_LOOKUP : ACT_FRESH, d, rand_mac(),
                   HOP_W'($urandom()));
      end else begin
        queue_word(ACT_TICK, rand_mac(), rand_mac(), HOP_W'($urandom()));
      end
    end
  endtask

  task automatic wait_idle();
    while (!(n_accepted == n_queued && expected_routes.size() == 0)) @(negedge clk);
  endtask

  // register writes only with the table idle
  task automatic write_stale_limit(logic [LIMIT_W-1:0] value);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  localparam logic [MAC_W-1:0] MAC_A = 48'h0123_4567_89AB;
  localparam logic [MAC_W-1:0] MAC_B = 48'hA5A5_5A5A_C3C3;
  localparam logic [MAC_W-1:0] MAC_C = 48'h5A5A_A5A5_3C3C;
  localparam logic [MAC_W-1:0] MAC_D = 48'h8000_0000_0001;

  initial begin
    logic [LIMIT_W-1:0] limits [N_PHASES];
    for (int i = 0; i < POOL_SZ; i++) begin
      dest_pool[i] = rand_mac();
      pool_hops[i] = '0;
    end
    limits[0] = '0;
    limits[1] = '1;
    limits[2] = LIMIT_W'($urandom_range(1, 8));
    limits[3] = LIMIT_W'($urandom_range(9, 200));
    limits[4] = LIMIT_W'(LIMIT_RESET);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, stale limit at its reset value
    queue_word(ACT_LOOKUP, '1, '0, '0);           // empty table: miss
    queue_word(ACT_FRESH, '0, '1, '1);            // empty table: miss
    queue_word(ACT_ADD, '0, '1, 8'd255);          // new, extreme fields
    queue_word(ACT_ADD, '1, '0, 8'd0);            // new, opposite extremes
    queue_word(ACT_ADD, MAC_A, MAC_B, 8'd10);
    queue_word(ACT_LOOKUP, '0, '0, '0);           // hit
    queue_word(ACT_LOOKUP, '1, '1, '1);           // hit
    queue_word(ACT_ADD, MAC_A, MAC_C, 8'd10);     // equal count: no change
    queue_word(ACT_ADD, MAC_A, MAC_C, 8'd11);     // longer: no change
    queue_word(ACT_LOOKUP, MAC_A, '0, '0);        // still the first route
    queue_word(ACT_ADD, MAC_A, MAC_C, 8'd9);      // shorter: replaced
    queue_word(ACT_ADD, '0, MAC_B, 8'd254);       // shorter by one
    queue_word(ACT_ADD, '1, MAC_C, 8'd0);         // zero can't be beaten
    queue_word(ACT_TICK, '1, '1, '1);             // payload ignored
    queue_word(ACT_FRESH, MAC_A, '0, '0);         // age 1, within limit
    queue_word(ACT_LOOKUP, MAC_A ^ 48'h1, '0, '0); // near miss
    queue_word(ACT_TICK, MAC_A, MAC_B, 8'h5A);
    queue_word(ACT_FRESH, '0, '0, '0);
    queue_word(ACT_ADD, MAC_D, MAC_A, 8'd128);    // stamped at second 2
    queue_word(ACT_FRESH, MAC_D, '0, '0);
    queue_word(ACT_LOOKUP, MAC_D, '1, '1);

    // random part, one batch per stale_limit setting
    for (int p = 0; p < N_PHASES; p++) begin
      write_stale_limit(limits[p]);
      queue_random_words(PHASE_LEN);
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d words (%0d adds, %0d lookups, %0d ticks), %0d results checked",
             n_accepted, n_adds, n_lookups, n_ticks, n_results);
    $display("%0d writes, %0d drops, %0d hits, %0d stale; limits %0d/%0d/%0d/%0d/%0d",
             n_updates, n_drops, n_hits, n_stale, limits[0], limits[1], limits[2],
             limits[3], limits[4]);
    if (fail_cnt == 0 && expected_routes.size() == 0) begin
      $display("[route_table_with_aging] OK");
    end else begin
      $display("%0d failures, %0d results still expected", fail_cnt, expected_routes.size());
      $display("[route_table_with_aging] ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout: %0d of %0d words accepted, %0d results", n_accepted, n_queued,
             n_results);
    $display("[route_table_with_aging] ERROR");
    $finish;
  end

endmodule
